FILE: hw/rtl/mmcfp_pkg.sv
// ----------------------------------------------------------------------------
// mmcfp_pkg
// shared types, widths and range tables for the motor command frame packer
// ----------------------------------------------------------------------------
package mmcfp_pkg;

    localparam int VAL_W       = 29;   // signed q12.16 command value
    localparam int KIND_W      = 2;
    localparam int IDENT_W     = 11;
    localparam int CODE_W      = 16;   // widest code (position)
    localparam int NARROW_W    = 12;   // velocity, gains and torque codes
    localparam int D_W         = 25;   // offset above range minimum
    localparam int P_W         = D_W + CODE_W;
    localparam int T_W         = 21;   // scaled offset after power-of-two shift
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 24;
    localparam int DIV_W       = 7;
    localparam int SHIFT_W     = 5;
    localparam int LANES       = 5;
    localparam int LANE_ID_W   = 3;
    localparam int TDATA_IN_W  = 160;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 80;

    localparam logic [LANE_ID_W-1:0] LANE_POS = 3'd0;
    localparam logic [LANE_ID_W-1:0] LANE_VEL = 3'd1;
    localparam logic [LANE_ID_W-1:0] LANE_KP  = 3'd2;
    localparam logic [LANE_ID_W-1:0] LANE_KD  = 3'd3;
    localparam logic [LANE_ID_W-1:0] LANE_TRQ = 3'd4;

    localparam logic [KIND_W-1:0] KIND_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_B = 2'd1;

    // span = 2^shift * divisor, recip = floor(2^24 / divisor)
    typedef struct packed {
        logic signed [VAL_W-1:0]   lo;
        logic signed [VAL_W-1:0]   hi;
        logic                      wide;
        logic [SHIFT_W-1:0]        shift;
        logic [DIV_W-1:0]          divisor;
        logic [RECIP_W-1:0]        recip;
    } t_lane_cfg;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

    function automatic t_lane_cfg mk_cfg(input int lim_lo, input int lim_hi,
                                         input logic wide, input int shift,
                                         input int divisor, input int recip);
        t_lane_cfg c;
        c.lo      = VAL_W'(lim_lo);
        c.hi      = VAL_W'(lim_hi);
        c.wide    = wide;
        c.shift   = SHIFT_W'(shift);
        c.divisor = DIV_W'(divisor);
        c.recip   = RECIP_W'(recip);
        return c;
    endfunction

    // unused kind code falls back to the last row
    function automatic t_lane_cfg lane_cfg(input logic [LANE_ID_W-1:0] lane,
                                           input logic [KIND_W-1:0] kind);
        t_lane_cfg c;
        unique case (lane)
            LANE_POS: c = mk_cfg(-819200, 819200, 1'b1, 16, 25, 671088);
            LANE_VEL: begin
                if (kind == KIND_A) begin
                    c = mk_cfg(-1638400, 1638400, 1'b0, 17, 25, 671088);
                end else if (kind == KIND_B) begin
                    c = mk_cfg(-2949120, 2949120, 1'b0, 17, 45, 372827);
                end else begin
                    c = mk_cfg(-1966080, 1966080, 1'b0, 18, 15, 1118481);
                end
            end
            LANE_KP:  c = mk_cfg(0, 32768000, 1'b0, 18, 125, 134217);
            LANE_KD:  c = mk_cfg(0, 327680, 1'b0, 16, 5, 3355443);
            LANE_TRQ: begin
                if (kind == KIND_A) begin
                    c = mk_cfg(-1310720, 1310720, 1'b0, 19, 5, 3355443);
                end else if (kind == KIND_B) begin
                    c = mk_cfg(-1572864, 1572864, 1'b0, 20, 3, 5592405);
                end else begin
                    c = mk_cfg(-655360, 655360, 1'b0, 18, 5, 3355443);
                end
            end
            default:  c = mk_cfg(-819200, 819200, 1'b1, 16, 25, 671088);
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/mit_motor_command_frame_pack.sv
// ----------------------------------------------------------------------------
// mit_motor_command_frame_pack
// clamps and scales five motor commands and packs them into an eight byte frame
// ----------------------------------------------------------------------------
// path: an input transfer is registered in stages one to four in order; stage four drives output valid
// throughput: one transfer per cycle while the output is not stalled; the four lane stages run concurrently
// each stage holds only when it is full and the stage after it holds
// reset: synchronous, active low, clears the stage valid bits only
// ----------------------------------------------------------------------------
module mit_motor_command_frame_pack (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // frame_ident, position_cmd, velocity_cmd, stiffness_cmd, damping_cmd,
    // torque_cmd, zero pad
    input  logic [mmcfp_pkg::TDATA_IN_W-1:0]      i_s_axis_tdata,
    // motor_kind
    input  logic [mmcfp_pkg::TUSER_IN_W-1:0]      i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // out_ident, byte_0 .. byte_7, zero pad
    output logic [mmcfp_pkg::TDATA_OUT_W-1:0]     o_m_axis_tdata
);

    localparam int VAL0 = mmcfp_pkg::IDENT_W;

    // per-stage valid bits, stage four is the output register
    logic r_v1, r_v2, r_v3, r_v4;
    logic n_v1, n_v2, n_v3, n_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    mmcfp_pkg::t_stage_en en;

    // ident rides alongside the lanes
    logic [mmcfp_pkg::IDENT_W-1:0] r_id1, r_id2, r_id3, r_id4;

    logic [mmcfp_pkg::CODE_W-1:0] codes [mmcfp_pkg::LANES];
    logic [mmcfp_pkg::KIND_W-1:0] kind;

    // bubble-collapsing ready chain from the output back to the input
    always_comb begin
        rdy4 = !r_v4 || i_m_axis_tready;
        rdy3 = !r_v3 || rdy4;
        rdy2 = !r_v2 || rdy3;
        rdy1 = !r_v1 || rdy2;
        en.s1 = rdy1;
        en.s2 = rdy2;
        en.s3 = rdy3;
        en.s4 = rdy4;
        n_v1 = rdy1 ? i_s_axis_tvalid : r_v1;
        n_v2 = rdy2 ? r_v1 : r_v2;
        n_v3 = rdy3 ? r_v2 : r_v3;
        n_v4 = rdy4 ? r_v3 : r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) r_id1 <= i_s_axis_tdata[mmcfp_pkg::IDENT_W-1:0];
        if (en.s2) r_id2 <= r_id1;
        if (en.s3) r_id3 <= r_id2;
        if (en.s4) r_id4 <= r_id3;
    end

    assign kind = i_s_axis_tuser[mmcfp_pkg::KIND_W-1:0];

    // one lane per command value, ranges picked by lane and motor kind
    for (genvar g = 0; g < mmcfp_pkg::LANES; g++) begin : g_lane
        mmcfp_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_value (i_s_axis_tdata[VAL0 + g*mmcfp_pkg::VAL_W +: mmcfp_pkg::VAL_W]),
            .i_cfg   (mmcfp_pkg::lane_cfg(mmcfp_pkg::LANE_ID_W'(g), kind)),
            .o_code  (codes[g])
        );
    end

    // frame assembly from the lane results
    mmcfp_merge u_merge (
        .i_ident (r_id4),
        .i_pos   (codes[mmcfp_pkg::LANE_POS]),
        .i_vel   (codes[mmcfp_pkg::LANE_VEL]),
        .i_kp    (codes[mmcfp_pkg::LANE_KP]),
        .i_kd    (codes[mmcfp_pkg::LANE_KD]),
        .i_trq   (codes[mmcfp_pkg::LANE_TRQ]),
        .o_tdata (o_m_axis_tdata)
    );

    assign o_s_axis_tready = rdy1;
    assign o_m_axis_tvalid = r_v4;

endmodule

FILE: hw/rtl/mmcfp_lane.sv
// ----------------------------------------------------------------------------
// mmcfp_lane
// four-stage clamp and scale of one command value to its unsigned code
// ----------------------------------------------------------------------------
module mmcfp_lane (
    input  logic                                i_clk,
    input  mmcfp_pkg::t_stage_en                i_en,
    input  logic signed [mmcfp_pkg::VAL_W-1:0]  i_value,
    input  mmcfp_pkg::t_lane_cfg                i_cfg,
    output logic [mmcfp_pkg::CODE_W-1:0]        o_code
);

    // stage 1: bound compare and offset
    logic                                r_s1_hi, r_s1_lo;
    logic [mmcfp_pkg::D_W-1:0]           r_s1_d;
    mmcfp_pkg::t_lane_cfg                r_s1_cfg;
    // stage 2: scale by full code then drop power-of-two part of span
    logic                                r_s2_hi, r_s2_lo;
    logic [mmcfp_pkg::T_W-1:0]           r_s2_t;
    mmcfp_pkg::t_lane_cfg                r_s2_cfg;
    // stage 3: reciprocal estimate of the quotient
    logic                                r_s3_hi, r_s3_lo;
    logic [mmcfp_pkg::T_W-1:0]           r_s3_t;
    logic [mmcfp_pkg::CODE_W-1:0]        r_s3_q;
    mmcfp_pkg::t_lane_cfg                r_s3_cfg;
    // stage 4: corrected, saturated code
    logic [mmcfp_pkg::CODE_W-1:0]        r_code;

    logic signed [mmcfp_pkg::VAL_W:0]                  diff;
    logic [mmcfp_pkg::P_W-1:0]                         d_ext, prod_full, shifted;
    logic [mmcfp_pkg::T_W+mmcfp_pkg::RECIP_W-1:0]      prod_recip;
    logic [mmcfp_pkg::CODE_W+mmcfp_pkg::DIV_W-1:0]     q_times_m;
    logic [mmcfp_pkg::T_W-1:0]                         rem;
    logic                                              corr;
    logic [mmcfp_pkg::CODE_W-1:0]                      full, n_code;

    always_comb begin
        diff = {i_value[mmcfp_pkg::VAL_W-1], i_value}
             - {i_cfg.lo[mmcfp_pkg::VAL_W-1], i_cfg.lo};
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1_hi  <= (i_value >= i_cfg.hi);
            r_s1_lo  <= (i_value <= i_cfg.lo);
            r_s1_d   <= diff[mmcfp_pkg::D_W-1:0];
            r_s1_cfg <= i_cfg;
        end
    end

    // d * (2^bits - 1) as shift and subtract
    always_comb begin
        d_ext = {{mmcfp_pkg::CODE_W{1'b0}}, r_s1_d};
        if (r_s1_cfg.wide) begin
            prod_full = (d_ext << mmcfp_pkg::CODE_W) - d_ext;
        end else begin
            prod_full = (d_ext << mmcfp_pkg::NARROW_W) - d_ext;
        end
        shifted = prod_full >> r_s1_cfg.shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_hi  <= r_s1_hi;
            r_s2_lo  <= r_s1_lo;
            r_s2_t   <= shifted[mmcfp_pkg::T_W-1:0];
            r_s2_cfg <= r_s1_cfg;
        end
    end

    always_comb begin
        prod_recip = {{mmcfp_pkg::RECIP_W{1'b0}}, r_s2_t}
                   * {{mmcfp_pkg::T_W{1'b0}}, r_s2_cfg.recip};
    end

    // estimate is exact or one low
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_hi  <= r_s2_hi;
            r_s3_lo  <= r_s2_lo;
            r_s3_t   <= r_s2_t;
            r_s3_q   <= prod_recip[mmcfp_pkg::RECIP_SHIFT +: mmcfp_pkg::CODE_W];
            r_s3_cfg <= r_s2_cfg;
        end
    end

    always_comb begin
        q_times_m = {{mmcfp_pkg::DIV_W{1'b0}}, r_s3_q}
                  * {{mmcfp_pkg::CODE_W{1'b0}}, r_s3_cfg.divisor};
        rem  = r_s3_t - q_times_m[mmcfp_pkg::T_W-1:0];
        corr = (rem >= {{(mmcfp_pkg::T_W-mmcfp_pkg::DIV_W){1'b0}}, r_s3_cfg.divisor});
        full = r_s3_cfg.wide ? {mmcfp_pkg::CODE_W{1'b1}}
                             : {{(mmcfp_pkg::CODE_W-mmcfp_pkg::NARROW_W){1'b0}},
                                {mmcfp_pkg::NARROW_W{1'b1}}};
        priority if (r_s3_hi) begin
            n_code = full;
        end else if (r_s3_lo) begin
            n_code = '0;
        end else begin
            n_code = r_s3_q + {{(mmcfp_pkg::CODE_W-1){1'b0}}, corr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_code <= n_code;
        end
    end

    assign o_code = r_code;

endmodule

FILE: hw/rtl/mmcfp_merge.sv
// ----------------------------------------------------------------------------
// mmcfp_merge
// packs the five lane codes big-endian into eight frame bytes with the ident
// ----------------------------------------------------------------------------
module mmcfp_merge (
    input  logic [mmcfp_pkg::IDENT_W-1:0]     i_ident,
    input  logic [mmcfp_pkg::CODE_W-1:0]      i_pos,
    input  logic [mmcfp_pkg::CODE_W-1:0]      i_vel,
    input  logic [mmcfp_pkg::CODE_W-1:0]      i_kp,
    input  logic [mmcfp_pkg::CODE_W-1:0]      i_kd,
    input  logic [mmcfp_pkg::CODE_W-1:0]      i_trq,
    output logic [mmcfp_pkg::TDATA_OUT_W-1:0] o_tdata
);

    logic [7:0] frame [8];

    always_comb begin
        frame[0] = i_pos[15:8];
        frame[1] = i_pos[7:0];
        frame[2] = i_vel[11:4];
        frame[3] = {i_vel[3:0], i_kp[11:8]};
        frame[4] = i_kp[7:0];
        frame[5] = i_kd[11:4];
        frame[6] = {i_kd[3:0], i_trq[11:8]};
        frame[7] = i_trq[7:0];
        o_tdata  = {5'b0, frame[7], frame[6], frame[5], frame[4],
                    frame[3], frame[2], frame[1], frame[0], i_ident};
    end

endmodule

FILE: hw/rtl/mmcfp_checker.sv
// ----------------------------------------------------------------------------
// mmcfp_checker
// port-level checks on the frame packer, bound to the top level
// ----------------------------------------------------------------------------
module mmcfp_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  o_s_axis_tready,
    input  logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    input  logic [mmcfp_pkg::TDATA_OUT_W-1:0]     o_m_axis_tdata
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output transfer dropped while stalled");

    // a held result keeps its frame
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output frame changed while stalled");

    // empty output stage means the whole pipe can take a transfer
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input refused while output stage empty");

    // pad bits above the frame stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[79:75] == 5'b0)
        else $error("output pad bits set");

    // reset empties the output stage
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind mit_motor_command_frame_pack mmcfp_checker u_mmcfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
